// File: rtl/opsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opsc_pkg
// Shared types, codes and header-step functions of the packet stream
// classifier.
// ----------------------------------------------------------------------------
package opsc_pkg;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_NEWLEN   = 3'd1,
      PH_LENBYTES = 3'd2,
      PH_BODY     = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   // result codes
   localparam logic [2:0] DT_UNKNOWN  = 3'd0;
   localparam logic [2:0] DT_SIGNED   = 3'd1;
   localparam logic [2:0] DT_DETACHED = 3'd2;
   localparam logic [2:0] DT_KEY      = 3'd3;
   localparam logic [2:0] DT_ENCRYPT  = 3'd4;
   localparam logic [2:0] DT_OTHER    = 3'd5;

   localparam logic [1:0] SR_DECIDED   = 2'd0;
   localparam logic [1:0] SR_BOUNDARY  = 2'd1;
   localparam logic [1:0] SR_IN_BODY   = 2'd2;
   localparam logic [1:0] SR_MALFORMED = 2'd3;

   // packet kinds
   localparam logic [5:0] KIND_PKESK      = 6'd1;
   localparam logic [5:0] KIND_SIG        = 6'd2;
   localparam logic [5:0] KIND_SKESK      = 6'd3;
   localparam logic [5:0] KIND_ONEPASS    = 6'd4;
   localparam logic [5:0] KIND_SECKEY     = 6'd5;
   localparam logic [5:0] KIND_PUBKEY     = 6'd6;
   localparam logic [5:0] KIND_SECSUB     = 6'd7;
   localparam logic [5:0] KIND_COMPRESSED = 6'd8;
   localparam logic [5:0] KIND_MARKER     = 6'd10;
   localparam logic [5:0] KIND_LITERAL    = 6'd11;
   localparam logic [5:0] KIND_PUBSUB     = 6'd14;

   // image file lead bytes
   localparam logic [7:0] PNG_B0 = 8'h89;
   localparam logic [7:0] PNG_B1 = 8'h50;
   localparam logic [7:0] PNG_B2 = 8'h4E;
   localparam logic [7:0] PNG_B3 = 8'h47;

   localparam logic [1:0] PNG_NONE    = 2'd0;
   localparam logic [1:0] PNG_LEAD1   = 2'd1;
   localparam logic [1:0] PNG_LEAD2   = 2'd2;
   localparam logic [1:0] PNG_PENDING = 2'd3;

   localparam logic [7:0] LEN_TWO_LO  = 8'd192;
   localparam logic [7:0] LEN_PART_LO = 8'd224;
   localparam logic [7:0] LEN_FOUR    = 8'd255;

   // result queue
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [2:0] data_type;
      logic [1:0] stop_reason;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } push_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  len_left;
      logic [31:0] body_rem;
      logic [7:0]  len_first;
      logic [5:0]  kind;
      logic        seen;
      logic        only_sig;
      logic [1:0]  png;
   } parse_state_type;

   typedef struct packed {
      parse_state_type st;
      logic            emit;
      result_type      res;
   } step_type;

   localparam parse_state_type ST_RESET = '{PH_HEADER, 3'd0, 32'd0, 8'd0, 6'd0,
                                            1'b0, 1'b0, PNG_NONE};

   function automatic step_type put_result(step_type s, logic [2:0] dt, logic [1:0] sr);
      step_type r;
      r = s;
      r.emit = 1'b1;
      r.res.data_type = dt;
      r.res.stop_reason = sr;
      r.st.phase = PH_DONE;
      return r;
   endfunction

   function automatic logic [2:0] fallback_type(step_type s);
      return s.st.only_sig ? DT_DETACHED : DT_UNKNOWN;
   endfunction

   function automatic step_type malformed(step_type s);
      return put_result(s, fallback_type(s), SR_MALFORMED);
   endfunction

   function automatic step_type end_of_sample(step_type s);
      return put_result(s, fallback_type(s),
                        (s.st.body_rem == 32'd0) ? SR_BOUNDARY : SR_IN_BODY);
   endfunction

   function automatic step_type count_signature(step_type s);
      step_type r;
      r = s;
      if (!r.st.seen) begin
         r.st.only_sig = 1'b1;
      end
      r.st.seen = 1'b1;
      return r;
   endfunction

   function automatic step_type header_done(step_type s, logic lst);
      step_type   r;
      logic       first;
      logic       prior;
      logic       dec;
      logic [2:0] dt;
      r = s;
      first = !s.st.seen;
      prior = s.st.only_sig;
      dec = 1'b0;
      dt = DT_OTHER;
      if (!(s.st.kind inside {[6'd1:6'd14], [6'd16:6'd19]})) begin
         r = malformed(s);
      end else if (s.st.png == PNG_PENDING && !lst) begin
         r.st.phase = PH_BODY;
      end else begin
         r.st.png = PNG_NONE;
         if (first && s.st.kind == KIND_MARKER) begin
            dec = 1'b0;
         end else if (s.st.kind == KIND_SIG) begin
            r = count_signature(r);
         end else begin
            r.st.only_sig = 1'b0;
            r.st.seen = 1'b1;
            dec = 1'b1;
            case (s.st.kind)
               KIND_LITERAL: begin
                  dec = prior;
                  dt = DT_SIGNED;
               end
               KIND_ONEPASS:             dt = DT_SIGNED;
               KIND_SECKEY, KIND_PUBKEY: dt = DT_KEY;
               KIND_SECSUB, KIND_PUBSUB: dt = DT_OTHER;
               KIND_PKESK, KIND_SKESK:   dt = DT_ENCRYPT;
               KIND_COMPRESSED:          dt = first ? DT_SIGNED : DT_OTHER;
               default:                  dt = DT_OTHER;
            endcase
         end
         if (dec) begin
            r = put_result(r, dt, SR_DECIDED);
         end else if (lst) begin
            r = end_of_sample(r);
         end else begin
            r.st.phase = (r.st.body_rem == 32'd0) ? PH_HEADER : PH_BODY;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/opsc_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opsc_parse
// Front end: accepts bytes, walks packet headers, counts bodies down and
// pushes the classification result into the queue.
// ----------------------------------------------------------------------------
module opsc_parse
   import opsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last,
   input  wire logic       q_full,
   output push_type        push
);

   parse_state_type st_ff;
   parse_state_type st_in;
   step_type        step;
   logic            accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  lf_off;
      logic [31:0] two_len;
      logic [2:0]  ll;
      b = req_data_byte;
      lf_off = st_ff.len_first - LEN_TWO_LO;
      two_len = {16'd0, lf_off, 8'd0} + {24'd0, b} + {24'd0, LEN_TWO_LO};
      ll = 3'd0;
      step = '{st: st_ff, emit: 1'b0, res: '{DT_UNKNOWN, SR_DECIDED}};
      case (st_ff.phase)
         PH_HEADER: begin
            step.st.png = (b == PNG_B0) ? PNG_LEAD1 : PNG_NONE;
            step.st.body_rem = 32'd0;
            step.st.len_first = 8'd0;
            if (!b[7]) begin
               step = malformed(step);
            end else if (b[6]) begin
               step.st.kind = b[5:0];
               step.st.phase = PH_NEWLEN;
               if (req_last) begin
                  step = malformed(step);
               end
            end else begin
               step.st.kind = {2'b00, b[5:2]};
               ll = (b[1:0] == 2'd3) ? 3'd0 : (3'd1 << b[1:0]);
               step.st.len_left = ll;
               if (ll == 3'd0) begin
                  step = header_done(step, req_last);
               end else begin
                  step.st.phase = PH_LENBYTES;
                  if (req_last) begin
                     step = malformed(step);
                  end
               end
            end
         end
         PH_NEWLEN: begin
            if (b < LEN_TWO_LO) begin
               step.st.body_rem = {24'd0, b};
               step = header_done(step, req_last);
            end else if (b < LEN_PART_LO || b == LEN_FOUR) begin
               step.st.len_first = (b == LEN_FOUR) ? 8'd0 : b;
               step.st.len_left = (b == LEN_FOUR) ? 3'd4 : 3'd1;
               step.st.phase = PH_LENBYTES;
               if (req_last) begin
                  step = malformed(step);
               end
            end else begin
               step.st.body_rem = 32'd0;
               step = header_done(step, req_last);
            end
         end
         PH_LENBYTES: begin
            if (st_ff.png == PNG_LEAD1 && b == PNG_B1) begin
               step.st.png = PNG_LEAD2;
            end else if (st_ff.png == PNG_LEAD2 && b == PNG_B2) begin
               step.st.png = PNG_PENDING;
            end else begin
               step.st.png = PNG_NONE;
            end
            if (st_ff.len_left == 3'd1 && st_ff.len_first >= LEN_TWO_LO
                && st_ff.len_first < LEN_PART_LO) begin
               step.st.body_rem = two_len;
            end else begin
               step.st.body_rem = {st_ff.body_rem[23:0], b};
            end
            ll = (st_ff.len_left != 3'd0) ? st_ff.len_left - 3'd1 : 3'd0;
            step.st.len_left = ll;
            if (ll == 3'd0) begin
               step = header_done(step, req_last);
            end else if (req_last) begin
               step = malformed(step);
            end
         end
         PH_BODY: begin
            if (st_ff.png == PNG_PENDING && b == PNG_B3) begin
               step.st.png = PNG_NONE;
               step = malformed(step);
            end else begin
               if (st_ff.png == PNG_PENDING) begin
                  step.st.png = PNG_NONE;
                  step = count_signature(step);
               end
               if (st_ff.body_rem != 32'd0) begin
                  step.st.body_rem = st_ff.body_rem - 32'd1;
               end
               if (req_last) begin
                  step = end_of_sample(step);
               end else if (step.st.body_rem == 32'd0) begin
                  step.st.phase = PH_HEADER;
               end
            end
         end
         PH_DONE: begin
            step.emit = 1'b0;
         end
         default: begin
            step.emit = 1'b0;
         end
      endcase
      if (req_last) begin
         step.st = ST_RESET;
      end
   end

   assign st_in = accept ? step.st : st_ff;

   assign push.valid = accept && step.emit;
   assign push.res   = step.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/opsc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opsc_queue
// Short result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module opsc_queue
   import opsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            full,
   input  wire logic       pop,
   output logic            empty,
   output result_type      pop_data
);

   result_type        mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.res;
      end
   end

endmodule
`default_nettype wire

// File: rtl/opsc_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opsc_emit
// Back end: output register that takes results from the queue and holds
// them on the response channel until transferred.
// ----------------------------------------------------------------------------
module opsc_emit
   import opsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_empty,
   input  wire result_type q_data,
   output logic            q_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_data_type,
   output logic [1:0]      rsp_stop_reason
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign q_pop    = !q_empty && (!valid_ff || rsp_ready);
   assign valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load on pop, hold otherwise
   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff <= q_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_type   = res_ff.data_type;
   assign rsp_stop_reason = res_ff.stop_reason;

endmodule
`default_nettype wire

// File: rtl/openpgp_packet_stream_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// openpgp_packet_stream_classifier_core
// Classifies a byte sample by its packet headers, one byte per cycle.
//
// Input channel req_: one sample byte per transfer, req_last on the final
// byte. Output channel rsp_: one result per sample (data type, stop reason),
// given at the first deciding header, at a malformed header or at the last
// byte; bytes after a result are consumed silently up to req_last.
// A byte is taken every cycle while the result queue has room. Header
// decode and body countdown are combinational in the parser; a result is
// written into the queue at the edge at which the byte that caused it is
// transferred, and moves on in order to the output register as that frees.
// The parser and the output register are parted by a two-entry queue, so
// a stalled receiver only stops input once the queue is full; results stay
// held on the rsp_ ports until transferred.
// Synchronous reset empties the queue and the output register and starts
// a new sample at the next byte.
// ----------------------------------------------------------------------------
module openpgp_packet_stream_classifier_core
   import opsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_data_type,
   output logic [1:0]      rsp_stop_reason
);

   push_type   push;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   result_type q_data;

   opsc_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .q_full        (q_full),
      .push          (push)
   );

   opsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_data (q_data)
   );

   opsc_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_type   (rsp_data_type),
      .rsp_stop_reason (rsp_stop_reason)
   );

endmodule
`default_nettype wire
